// File: src/sc2asc_pkg.sv
`default_nettype none

package sc2asc_pkg;

  localparam int unsigned KeyTableSizeDefault = 128;

  localparam logic [7:0] PREFIX_EXT = 8'hE0;
  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_CAPS   = 7'h3A;
  localparam logic [6:0] LOWER_A    = 7'h61;
  localparam logic [6:0] LOWER_Z    = 7'h7A;
  localparam logic [6:0] UPPER_A    = 7'h41;
  localparam logic [6:0] UPPER_Z    = 7'h5A;
  localparam logic [6:0] CASE_DELTA = 7'd32;

  typedef logic [7:0] scan_byte_t;
  typedef logic [6:0] ascii_char_t;

  typedef struct packed {
    logic        emit;
    ascii_char_t ch;
    logic        shift_held;
    logic        caps_lock_on;
  } dec_res_t;

  function automatic ascii_char_t key_char(input logic [6:0] key, input logic shifted);
    ascii_char_t p;
    ascii_char_t s;
    p = 7'h00;
    s = 7'h00;
    case (key)
      7'd1:  begin p = 7'h1B; s = 7'h1B; end
      7'd2:  begin p = 7'h31; s = 7'h21; end
      7'd3:  begin p = 7'h32; s = 7'h40; end
      7'd4:  begin p = 7'h33; s = 7'h23; end
      7'd5:  begin p = 7'h34; s = 7'h24; end
      7'd6:  begin p = 7'h35; s = 7'h25; end
      7'd7:  begin p = 7'h36; s = 7'h5E; end
      7'd8:  begin p = 7'h37; s = 7'h26; end
      7'd9:  begin p = 7'h38; s = 7'h2A; end
      7'd10: begin p = 7'h39; s = 7'h28; end
      7'd11: begin p = 7'h30; s = 7'h29; end
      7'd12: begin p = 7'h2D; s = 7'h5F; end
      7'd13: begin p = 7'h3D; s = 7'h2B; end
      7'd14: begin p = 7'h08; s = 7'h08; end
      7'd15: begin p = 7'h09; s = 7'h09; end
      7'd16: begin p = 7'h71; s = 7'h51; end
      7'd17: begin p = 7'h77; s = 7'h57; end
      7'd18: begin p = 7'h65; s = 7'h45; end
      7'd19: begin p = 7'h72; s = 7'h52; end
      7'd20: begin p = 7'h74; s = 7'h54; end
      7'd21: begin p = 7'h79; s = 7'h59; end
      7'd22: begin p = 7'h75; s = 7'h55; end
      7'd23: begin p = 7'h69; s = 7'h49; end
      7'd24: begin p = 7'h6F; s = 7'h4F; end
      7'd25: begin p = 7'h70; s = 7'h50; end
      7'd26: begin p = 7'h5B; s = 7'h7B; end
      7'd27: begin p = 7'h5D; s = 7'h7D; end
      7'd28: begin p = 7'h0A; s = 7'h0A; end
      7'd30: begin p = 7'h61; s = 7'h41; end
      7'd31: begin p = 7'h73; s = 7'h53; end
      7'd32: begin p = 7'h64; s = 7'h44; end
      7'd33: begin p = 7'h66; s = 7'h46; end
      7'd34: begin p = 7'h67; s = 7'h47; end
      7'd35: begin p = 7'h68; s = 7'h48; end
      7'd36: begin p = 7'h6A; s = 7'h4A; end
      7'd37: begin p = 7'h6B; s = 7'h4B; end
      7'd38: begin p = 7'h6C; s = 7'h4C; end
      7'd39: begin p = 7'h3B; s = 7'h3A; end
      7'd40: begin p = 7'h27; s = 7'h22; end
      7'd41: begin p = 7'h60; s = 7'h7E; end
      7'd43: begin p = 7'h5C; s = 7'h7C; end
      7'd44: begin p = 7'h7A; s = 7'h5A; end
      7'd45: begin p = 7'h78; s = 7'h58; end
      7'd46: begin p = 7'h63; s = 7'h43; end
      7'd47: begin p = 7'h76; s = 7'h56; end
      7'd48: begin p = 7'h62; s = 7'h42; end
      7'd49: begin p = 7'h6E; s = 7'h4E; end
      7'd50: begin p = 7'h6D; s = 7'h4D; end
      7'd51: begin p = 7'h2C; s = 7'h3C; end
      7'd52: begin p = 7'h2E; s = 7'h3E; end
      7'd53: begin p = 7'h2F; s = 7'h3F; end
      7'd55: begin p = 7'h2A; s = 7'h2A; end
      7'd57: begin p = 7'h20; s = 7'h20; end
      default: begin p = 7'h00; s = 7'h00; end
    endcase
    return shifted ? s : p;
  endfunction

  function automatic ascii_char_t flip_case(input ascii_char_t c);
    ascii_char_t r;
    r = c;
    if (c >= LOWER_A && c <= LOWER_Z) begin
      r = c - CASE_DELTA;
    end else if (c >= UPPER_A && c <= UPPER_Z) begin
      r = c + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/sc2asc_if.sv
`default_nettype none

interface sc2asc_byte_if;
  logic                   valid;
  logic                   ready;
  sc2asc_pkg::scan_byte_t scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink (input valid, input scan_byte, output ready);
endinterface

interface sc2asc_char_if;
  logic                    valid;
  logic                    ready;
  sc2asc_pkg::ascii_char_t ascii_char;

  modport source (output valid, output ascii_char, input ready);
  modport sink (input valid, input ascii_char, output ready);
endinterface

`default_nettype wire

// File: src/sc2asc_in_stage.sv
`default_nettype none

module sc2asc_in_stage (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  sc2asc_byte_if.sink                 in_chan,
  input  wire logic                   advance,
  output logic                        valid_o,
  output sc2asc_pkg::scan_byte_t      byte_o
);
  import sc2asc_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  scan_byte_t byte_r;
  logic       load;

  assign in_chan.ready = !valid_r || advance;
  assign load          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_chan.scan_byte;
    end
  end

  assign valid_o = valid_r;
  assign byte_o  = byte_r;

endmodule

`default_nettype wire

// File: src/sc2asc_decode.sv
`default_nettype none

module sc2asc_decode #(
  parameter int unsigned KEY_TABLE_SIZE = sc2asc_pkg::KeyTableSizeDefault
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   valid_i,
  input  wire sc2asc_pkg::scan_byte_t byte_i,
  input  wire logic                   advance,
  output sc2asc_pkg::dec_res_t        res_o
);
  import sc2asc_pkg::*;

  localparam logic [7:0] TableLimit = 8'(KEY_TABLE_SIZE);

  logic        shift_r;
  logic        shift_nxt;
  logic        caps_r;
  logic        caps_nxt;
  logic [6:0]  key;
  logic        release_bit;
  logic        is_shift;
  ascii_char_t ch;
  logic        emit;

  assign key         = byte_i[6:0];
  assign release_bit = byte_i[7];
  assign is_shift    = (key == KEY_LSHIFT) || (key == KEY_RSHIFT);

  always_comb begin
    shift_nxt = shift_r;
    caps_nxt  = caps_r;
    ch        = 7'h00;
    emit      = 1'b0;
    if (byte_i == PREFIX_EXT) begin
      emit = 1'b0;
    end else if (release_bit) begin
      if (is_shift) begin
        shift_nxt = 1'b0;
      end
    end else if (is_shift) begin
      shift_nxt = 1'b1;
    end else if (key == KEY_CAPS) begin
      caps_nxt = !caps_r;
    end else begin
      if ({1'b0, key} < TableLimit) begin
        ch = key_char(key, shift_r);
      end
      if (caps_r) begin
        ch = flip_case(ch);
      end
      emit = (ch != 7'h00);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      caps_r  <= 1'b0;
    end else if (advance) begin
      shift_r <= shift_nxt;
      caps_r  <= caps_nxt;
    end
  end

  assign res_o.emit         = valid_i && emit;
  assign res_o.ch           = ch;
  assign res_o.shift_held   = shift_r;
  assign res_o.caps_lock_on = caps_r;

endmodule

`default_nettype wire

// File: src/sc2asc_out_stage.sv
`default_nettype none

module sc2asc_out_stage (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    load,
  input  wire sc2asc_pkg::ascii_char_t ch_i,
  output logic                         free_o,
  output logic                         valid_o,
  sc2asc_char_if.source                out_chan
);
  import sc2asc_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  ascii_char_t ch_r;

  assign free_o = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ch_r <= ch_i;
    end
  end

  assign out_chan.valid      = valid_r;
  assign out_chan.ascii_char = ch_r;
  assign valid_o             = valid_r;

endmodule

`default_nettype wire

// File: src/scancode_to_ascii_decoder_core.sv
`default_nettype none

// Set 1 scan code to ASCII decoder, US layout. Takes one scan byte per cycle and returns
// at most one character per byte. Each byte passes through the input register, then
// its character through the result register. Shift and caps lock state live in the
// decode stage and update as each byte leaves the input register. Bytes that give no
// character (prefix, releases, modifiers, keys with no symbol) leave without needing
// the result register, so input ready drops only while a character is held by a stalled
// sink and the byte behind it also yields a character.
module scancode_to_ascii_decoder_core #(
  parameter int unsigned KEY_TABLE_SIZE = sc2asc_pkg::KeyTableSizeDefault
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  sc2asc_byte_if.sink   in_chan,
  sc2asc_char_if.source out_chan
);
  import sc2asc_pkg::*;

  logic       s1_valid;
  scan_byte_t s1_byte;
  logic       s1_advance;
  logic       out_free;
  logic       out_valid;
  dec_res_t   res;

  sc2asc_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .advance (s1_advance),
    .valid_o (s1_valid),
    .byte_o  (s1_byte)
  );

  sc2asc_decode #(
    .KEY_TABLE_SIZE (KEY_TABLE_SIZE)
  ) u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .byte_i  (s1_byte),
    .advance (s1_advance),
    .res_o   (res)
  );

  assign s1_advance = s1_valid && (!res.emit || out_free);

  sc2asc_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (s1_advance && res.emit),
    .ch_i     (res.ch),
    .free_o   (out_free),
    .valid_o  (out_valid),
    .out_chan (out_chan)
  );

  a_release_silent: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && s1_byte[7] |-> !res.emit)
    else $error("release byte produced a character");

  a_caps_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance && s1_byte == {1'b0, KEY_CAPS} |=> res.caps_lock_on != $past(res.caps_lock_on))
    else $error("caps lock make did not toggle");

  a_shift_release: assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance && s1_byte[7] && (s1_byte[6:0] == KEY_LSHIFT || s1_byte[6:0] == KEY_RSHIFT)
    |=> !res.shift_held)
    else $error("shift release did not clear shift");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> s1_valid && out_valid && !out_chan.ready && res.emit)
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
